/* src/cefr_pkg.sv */
package cefr_pkg;

  localparam int unsigned RING_DEPTH_DEF = 2048;

  // operation codes carried in tuser
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_DRAIN  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_IGNORE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_EVENT_TYPE  = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // byte positions inside a header burst
  localparam logic [4:0] HDR_FIRST_CRC = 5'd2;
  localparam logic [4:0] HDR_LAST_DATA = 5'd18;
  localparam logic [4:0] HDR_LAST_CRC  = 5'd20;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_HEADER,
    CMD_SAMPLE,
    CMD_DRAIN
  } cmd_kind_e;

  // work handed from the front end to the back end
  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  status;
    logic [10:0] pending;
    logic [31:0] dropped;
    logic [31:0] seq_num;
    logic [31:0] time_ms;
    logic [31:0] temp_mc;
    logic [7:0]  first_ch;
    logic [7:0]  ch_count;
    logic [10:0] plen;
    logic [15:0] sample;
    logic        close;
  } cmd_t;

  typedef struct packed {
    logic [31:0] dropped;
    logic [10:0] pending;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [1:0]  status;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/cefr_front.sv */
module cefr_front import cefr_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   op_i,
  input  logic [31:0]  seq_num_i,
  input  logic [31:0]  time_ms_i,
  input  logic [31:0]  temp_mc_i,
  input  logic [7:0]   first_ch_i,
  input  logic [7:0]   ch_count_i,
  input  logic         has_high_gain_i,
  input  logic [15:0]  sample_i,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i,
  output cmd_t         cmd_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned CW = ((PW > 11) ? PW : 11) + 1;
  localparam logic [CW-1:0] MAX_USED = CW'(RING_DEPTH - 1);

  logic [PW-1:0] used_q, used_d;
  logic [8:0]    words_q, words_d;
  logic          open_q, open_d;
  logic [31:0]   drop_q, drop_d;

  logic          accept;
  logic [8:0]    hdr_words;
  logic [CW-1:0] need, used_w, used_n;
  logic [10:0]   plen;
  cmd_t          cmd;

  assign accept     = in_valid_i && cmd_ready_i;
  assign in_ready_o = cmd_ready_i;
  assign used_w     = CW'(used_q);

  assign hdr_words = has_high_gain_i ? {ch_count_i, 1'b0} : {1'b0, ch_count_i};
  assign plen      = 11'd14 + {1'b0, hdr_words, 1'b0};
  // sync, type and length, payload, crc
  assign need      = CW'(plen) + CW'(7);

  always_comb begin
    used_n  = used_w;
    words_d = words_q;
    open_d  = open_q;
    drop_d  = drop_q;
    cmd          = '0;
    cmd.kind     = CMD_NONE;
    cmd.status   = ST_IGNORE;
    cmd.seq_num  = seq_num_i;
    cmd.time_ms  = time_ms_i;
    cmd.temp_mc  = temp_mc_i;
    cmd.first_ch = first_ch_i;
    cmd.ch_count = ch_count_i;
    cmd.plen     = plen;
    cmd.sample   = sample_i;
    unique case (op_i)
      OP_HEADER: begin
        if (!open_q) begin
          if (used_w + need > MAX_USED) begin
            drop_d     = drop_q + 32'd1;
            cmd.status = ST_DROP;
          end else begin
            cmd.kind   = CMD_HEADER;
            cmd.status = ST_OK;
            cmd.close  = (hdr_words == 9'd0);
            if (hdr_words == 9'd0) begin
              used_n = used_w + CW'(21);
            end else begin
              used_n  = used_w + CW'(19);
              words_d = hdr_words;
              open_d  = 1'b1;
            end
          end
        end
      end
      OP_SAMPLE: begin
        if (open_q) begin
          cmd.kind   = CMD_SAMPLE;
          cmd.status = ST_OK;
          words_d    = words_q - 9'd1;
          if (words_q == 9'd1) begin
            cmd.close = 1'b1;
            open_d    = 1'b0;
            used_n    = used_w + CW'(4);
          end else begin
            used_n = used_w + CW'(2);
          end
        end
      end
      OP_DRAIN: begin
        if (used_q != '0) begin
          cmd.kind   = CMD_DRAIN;
          cmd.status = ST_OK;
          used_n     = used_w - CW'(1);
        end
      end
      default: begin
      end
    endcase
    used_d      = used_n[PW-1:0];
    cmd.pending = used_n[10:0];
    cmd.dropped = drop_d;
  end

  assign cmd_valid_o = in_valid_i;
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      words_q <= '0;
      open_q  <= 1'b0;
      drop_q  <= '0;
    end else if (accept) begin
      used_q  <= used_d;
      words_q <= words_d;
      open_q  <= open_d;
      drop_q  <= drop_d;
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_w <= MAX_USED)
    else $error("ring occupancy beyond capacity");

  a_closed_no_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> words_q == 9'd0)
    else $error("words left while no frame open");

  a_open_has_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> words_q != 9'd0)
    else $error("open frame with no words left");

endmodule

/* src/cefr_queue.sv */
module cefr_queue import cefr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* src/cefr_back.sv */
module cefr_back import cefr_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       cmd_valid_i,
  output logic       cmd_pop_o,
  input  cmd_t       cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(RING_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_SMP  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [7:0]  ring_mem [RING_DEPTH];
  logic [7:0]  rdata_q;

  logic [2:0]    state_q, state_d;
  logic [4:0]    idx_q, idx_d;
  cmd_t          cur_q, cur_d;
  logic [15:0]   crc_q, crc_d;
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [7:0]    byte_q, byte_d;
  logic          ovalid_q, ovalid_d;
  result_t       out_q, out_d;
  logic [7:0]    sync1_q, sync2_q, type_q;

  logic        we, re;
  logic [7:0]  wbyte, hdr_byte, smp_byte;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    unique case (idx_q)
      5'd0:    hdr_byte = sync1_q;
      5'd1:    hdr_byte = sync2_q;
      5'd2:    hdr_byte = type_q;
      5'd3:    hdr_byte = cur_q.plen[7:0];
      5'd4:    hdr_byte = {5'd0, cur_q.plen[10:8]};
      5'd5:    hdr_byte = cur_q.seq_num[7:0];
      5'd6:    hdr_byte = cur_q.seq_num[15:8];
      5'd7:    hdr_byte = cur_q.seq_num[23:16];
      5'd8:    hdr_byte = cur_q.seq_num[31:24];
      5'd9:    hdr_byte = cur_q.time_ms[7:0];
      5'd10:   hdr_byte = cur_q.time_ms[15:8];
      5'd11:   hdr_byte = cur_q.time_ms[23:16];
      5'd12:   hdr_byte = cur_q.time_ms[31:24];
      5'd13:   hdr_byte = cur_q.temp_mc[7:0];
      5'd14:   hdr_byte = cur_q.temp_mc[15:8];
      5'd15:   hdr_byte = cur_q.temp_mc[23:16];
      5'd16:   hdr_byte = cur_q.temp_mc[31:24];
      5'd17:   hdr_byte = cur_q.first_ch;
      5'd18:   hdr_byte = cur_q.ch_count;
      5'd19:   hdr_byte = crc_q[7:0];
      5'd20:   hdr_byte = crc_q[15:8];
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    smp_byte = cur_q.sample[7:0];
      2'd1:    smp_byte = cur_q.sample[15:8];
      2'd2:    smp_byte = crc_q[7:0];
      default: smp_byte = crc_q[15:8];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    crc_d     = crc_q;
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    byte_d    = byte_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    out_d     = out_q;
    we        = 1'b0;
    re        = 1'b0;
    wbyte     = hdr_byte;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          idx_d     = '0;
          byte_d    = 8'd0;
          unique case (cmd_i.kind)
            CMD_HEADER: state_d = S_HDR;
            CMD_SAMPLE: state_d = S_SMP;
            CMD_DRAIN: begin
              re      = 1'b1;
              rptr_d  = ptr_inc(rptr_q);
              state_d = S_RD;
            end
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_HDR: begin
        we     = 1'b1;
        wbyte  = hdr_byte;
        wptr_d = ptr_inc(wptr_q);
        idx_d  = idx_q + 5'd1;
        if (idx_q >= HDR_FIRST_CRC && idx_q <= HDR_LAST_DATA) begin
          crc_d = crc16_byte((idx_q == HDR_FIRST_CRC) ? CRC_INIT : crc_q, hdr_byte);
        end
        if (cur_q.close ? (idx_q == HDR_LAST_CRC) : (idx_q == HDR_LAST_DATA)) begin
          state_d = S_DONE;
        end
      end
      S_SMP: begin
        we     = 1'b1;
        wbyte  = smp_byte;
        wptr_d = ptr_inc(wptr_q);
        idx_d  = idx_q + 5'd1;
        if (!idx_q[1]) begin
          crc_d = crc16_byte(crc_q, smp_byte);
        end
        if (cur_q.close ? (idx_q == 5'd3) : (idx_q == 5'd1)) begin
          state_d = S_DONE;
        end
      end
      S_RD: begin
        byte_d  = rdata_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d         = 1'b1;
          out_d.status     = cur_q.status;
          out_d.byte_valid = (cur_q.kind == CMD_DRAIN);
          out_d.out_byte   = byte_q;
          out_d.pending    = cur_q.pending;
          out_d.dropped    = cur_q.dropped;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ring storage, one access per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      ring_mem[wptr_q] <= wbyte;
    end
    if (re) begin
      rdata_q <= ring_mem[rptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    byte_q <= byte_d;
    out_q  <= out_d;
    idx_q  <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      crc_q    <= CRC_INIT;
      wptr_q   <= '0;
      rptr_q   <= '0;
      ovalid_q <= 1'b0;
      sync1_q  <= '0;
      sync2_q  <= '0;
      type_q   <= '0;
    end else begin
      state_q  <= state_d;
      crc_q    <= crc_d;
      wptr_q   <= wptr_d;
      rptr_q   <= rptr_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SYNC_FIRST:  sync1_q <= cfg_data_i;
          REG_SYNC_SECOND: sync2_q <= cfg_data_i;
          REG_EVENT_TYPE:  type_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  a_hdr_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HDR |-> idx_q <= HDR_LAST_CRC)
    else $error("header burst ran past its last byte");

  a_smp_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SMP |-> idx_q <= 5'd3)
    else $error("sample burst ran past its last byte");

  a_rd_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> $past(state_q) == S_IDLE)
    else $error("ring read data used without a read");

endmodule

/* src/crc16_event_framer_ring_top.sv */
// flow: front end, two-entry queue, then header bytes (with the crc when the frame has no words),
//   sample bytes (with the crc on the last word) or a drain read in the ring, then the result;
//   ignored or dropped items skip the ring. throughput: the single-port byte ring takes one byte
//   per cycle during a burst; the back end takes a new item only once the last result is registered
// reset: pointers, fill count, open frame and drop count clear, crc to 0xFFFF, registers to 0;
//   ring contents are left undefined and need no clearing pass
module crc16_event_framer_ring_top import cefr_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // seq_num[31:0], time_ms[63:32], temp_mc[95:64], first_channel[103:96],
  // channel_count[111:104], has_high_gain[112], sample_word[128:113], zero pad
  input  logic [135:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], byte_valid[2], out_byte[10:3], pending_bytes[21:11],
  // dropped_frames[53:22], zero pad
  output logic [55:0]  m_axis_tdata,
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  // front end to queue
  logic    f_valid, f_ready;
  cmd_t    f_cmd;
  // queue to back end
  logic    q_valid, q_pop;
  cmd_t    q_cmd;
  result_t res;

  // registers are always writable, only while idle by contract
  assign cfg_ready_o = 1'b1;

  // classifies items and keeps occupancy, open frame and drop count
  cefr_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .op_i            (s_axis_tuser),
    .seq_num_i       (s_axis_tdata[31:0]),
    .time_ms_i       (s_axis_tdata[63:32]),
    .temp_mc_i       (s_axis_tdata[95:64]),
    .first_ch_i      (s_axis_tdata[103:96]),
    .ch_count_i      (s_axis_tdata[111:104]),
    .has_high_gain_i (s_axis_tdata[112]),
    .sample_i        (s_axis_tdata[128:113]),
    .cmd_valid_o     (f_valid),
    .cmd_ready_i     (f_ready),
    .cmd_o           (f_cmd)
  );

  // two-entry command queue decouples classification from ring writes
  cefr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  // byte ring, crc and drain reads; owns the result register
  cefr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (q_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule

/* test/crc16_event_framer_ring_top_tb.sv */
`timescale 1ns / 100ps

module crc16_event_framer_ring_top_tb import cefr_pkg::*;;

  localparam int unsigned RING_SZ         = RING_DEPTH_DEF;
  localparam int unsigned HDR_FIXED_BYTES = 14;  // seq, time, temp, first channel, count
  localparam int unsigned FRAME_OVERHEAD  = 7;   // two sync, type, length, crc
  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam logic [1:0]  REG_UNUSED      = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] seq;
    logic [31:0] tms;
    logic [31:0] temp;
    logic [7:0]  fch;
    logic [7:0]  cnt;
    logic        hg;
    logic [15:0] word;
  } frame_item_t;

  logic         clk_i;
  logic         rst_ni     = 1'b0;
  logic         src_valid  = 1'b0;
  logic [135:0] src_data   = '0;
  logic [1:0]   src_op     = OP_DRAIN;
  logic         sink_ready = 1'b0;
  logic         cfg_valid  = 1'b0;
  logic [1:0]   cfg_index  = REG_SYNC_FIRST;
  logic [7:0]   cfg_data   = '0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [55:0]  m_axis_tdata;
  logic         cfg_ready_o;

  // stimulus and expectations
  frame_item_t framer_items_q[$];
  result_t     result_due_q[$];
  frame_item_t cur_item;
  int unsigned n_enqueued = 0;
  int unsigned n_checked  = 0;
  int unsigned mismatches = 0;
  int unsigned src_idle_pct  = 30;
  int unsigned sink_idle_pct = 30;
  int unsigned drain_pct     = 15;

  // predictor state
  logic [7:0]  ring_mem [RING_SZ];
  int unsigned wr_ptr     = 0;
  int unsigned rd_ptr     = 0;
  logic [15:0] crc_acc    = CRC_INIT;
  int unsigned words_due  = 0;
  bit          frame_busy = 1'b0;
  logic [31:0] drop_cnt   = '0;
  logic [7:0]  sync0_r    = '0;
  logic [7:0]  sync1_r    = '0;
  logic [7:0]  type_r     = '0;

  // coverage tallies for the summary
  int unsigned frames_built = 0;
  int unsigned bytes_out    = 0;
  int unsigned peak_fill    = 0;

  crc16_event_framer_ring_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (src_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (src_data),
    .s_axis_tuser  (src_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (sink_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor: byte ring with crc over type byte through payload
  // ---------------------------------------------------------------------------
  function automatic int unsigned ring_fill();
    return (wr_ptr + RING_SZ - rd_ptr) % RING_SZ;
  endfunction

  function automatic void ring_put(input logic [7:0] b, input bit with_crc);
    logic fb;
    if (with_crc) begin
      // msb first, one data bit per shift
      for (int i = 7; i >= 0; i--) begin
        fb      = crc_acc[15] ^ b[i];
        crc_acc = {crc_acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
    end
    ring_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % RING_SZ;
  endfunction

  // little-endian halfword through the crc
  function automatic void ring_put16(input logic [15:0] v);
    ring_put(v[7:0], 1'b1);
    ring_put(v[15:8], 1'b1);
  endfunction

  function automatic void ring_put32(input logic [31:0] v);
    ring_put16(v[15:0]);
    ring_put16(v[31:16]);
  endfunction

  // crc trailer goes out low byte first and is not itself hashed
  function automatic void frame_seal();
    ring_put(crc_acc[7:0], 1'b0);
    ring_put(crc_acc[15:8], 1'b0);
    frame_busy = 1'b0;
    words_due  = 0;
    frames_built++;
  endfunction

  function automatic result_t ring_framer_step(input frame_item_t it);
    result_t     r;
    int unsigned words;
    int unsigned plen;
    r        = '0;
    r.status = ST_IGNORE;
    case (it.op)
      OP_HEADER: begin
        // a header while a frame is open is ignored, the open frame keeps its room
        if (!frame_busy) begin
          words = it.hg ? 2 * it.cnt : it.cnt;
          plen  = HDR_FIXED_BYTES + 2 * words;
          if (RING_SZ - 1 - ring_fill() < plen + FRAME_OVERHEAD) begin
            // whole frame must fit, otherwise drop it and count
            drop_cnt = drop_cnt + 1;
            r.status = ST_DROP;
          end else begin
            ring_put(sync0_r, 1'b0);
            ring_put(sync1_r, 1'b0);
            crc_acc = CRC_INIT;
            ring_put(type_r, 1'b1);
            ring_put16(plen[15:0]);
            ring_put32(it.seq);
            ring_put32(it.tms);
            ring_put32(it.temp);
            ring_put(it.fch, 1'b1);
            ring_put(it.cnt, 1'b1);
            words_due  = words;
            frame_busy = 1'b1;
            if (words_due == 0) frame_seal();
            r.status = ST_OK;
          end
        end
      end
      OP_SAMPLE: begin
        if (frame_busy) begin
          ring_put16(it.word);
          words_due--;
          if (words_due == 0) frame_seal();
          r.status = ST_OK;
        end
      end
      OP_DRAIN: begin
        if (ring_fill() != 0) begin
          r.out_byte   = ring_mem[rd_ptr];
          r.byte_valid = 1'b1;
          r.status     = ST_OK;
          rd_ptr = (rd_ptr + 1) % RING_SZ;
          bytes_out++;
        end
      end
      default: ;
    endcase
    r.pending = ring_fill();
    r.dropped = drop_cnt;
    if (ring_fill() > peak_fill) peak_fill = ring_fill();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: presents queued items, random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src_valid && s_axis_tready) begin
        result_due_q.push_back(ring_framer_step(cur_item));
      end
      if (!src_valid || s_axis_tready) begin
        if (framer_items_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_item = framer_items_q.pop_front();
          src_valid <= 1'b1;
          src_op    <= cur_item.op;
          src_data  <= {7'd0, cur_item.word, cur_item.hg, cur_item.cnt, cur_item.fch,
                        cur_item.temp, cur_item.tms, cur_item.seq};
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compare each result with the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      if (mismatches < 50) $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got_r;
    if (rst_ni) begin
      if (sink_ready && m_axis_tvalid) begin
        got_r = result_t'(m_axis_tdata[53:0]);
        if (result_due_q.size() == 0) begin
          if (mismatches < 50) $error("result with no item outstanding: 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          exp_r = result_due_q.pop_front();
          check_field("status", exp_r.status, got_r.status);
          check_field("byte_valid", exp_r.byte_valid, got_r.byte_valid);
          check_field("out_byte", exp_r.out_byte, got_r.out_byte);
          check_field("pending_bytes", exp_r.pending, got_r.pending);
          check_field("dropped_frames", exp_r.dropped, got_r.dropped);
          n_checked++;
        end
      end
      sink_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rnd_word32();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic frame_item_t rnd_item(input logic [1:0] op);
    frame_item_t it;
    it.op   = op;
    it.seq  = rnd_word32();
    it.tms  = rnd_word32();
    it.temp = rnd_word32();
    it.fch  = $urandom;
    it.cnt  = $urandom;
    it.hg   = $urandom;
    it.word = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
    return it;
  endfunction

  function automatic void enqueue(input frame_item_t it);
    framer_items_q.push_back(it);
    n_enqueued++;
  endfunction

  function automatic void queue_drains(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) enqueue(rnd_item(OP_DRAIN));
  endfunction

  // header plus n_words samples, drains sprinkled in between
  function automatic void queue_frame(input int unsigned cnt, input bit hg,
                                      input int unsigned n_words);
    frame_item_t it;
    it     = rnd_item(OP_HEADER);
    it.cnt = cnt;
    it.hg  = hg;
    enqueue(it);
    for (int unsigned i = 0; i < n_words; i++) begin
      if ($urandom_range(99) < drain_pct) enqueue(rnd_item(OP_DRAIN));
      enqueue(rnd_item(OP_SAMPLE));
    end
  endfunction

  // mostly well-formed frames, some drain bursts, some noise and short frames
  function automatic void queue_event_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned cnt;
    int unsigned words;
    int unsigned sent;
    bit          hg;
    start = framer_items_q.size();
    while (framer_items_q.size() - start < n_items) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: cnt = $urandom_range(4);
            6, 7, 8:          cnt = $urandom_range(24, 5);
            default:          cnt = $urandom_range(60, 25);
          endcase
          hg    = $urandom_range(1);
          words = hg ? 2 * cnt : cnt;
          sent  = words;
          // truncated frame: the next headers get ignored until it fills up
          if ($urandom_range(99) < 8) sent = $urandom_range(words);
          queue_frame(cnt, hg, sent);
          queue_drains($urandom_range((FRAME_OVERHEAD + HDR_FIXED_BYTES + 2 * words) * 3 / 2));
        end
        15, 16: queue_drains($urandom_range(40, 1));
        default: begin
          case ($urandom_range(3))
            0:       enqueue(rnd_item(OP_UNUSED));
            1:       enqueue(rnd_item(OP_SAMPLE));
            2:       enqueue(rnd_item(OP_DRAIN));
            default: enqueue(rnd_item(OP_HEADER));
          endcase
        end
      endcase
    end
  endfunction

  // hold off new items until every result is back, then let the block go quiet
  task automatic settle();
    do @(posedge clk_i); while (n_checked != n_enqueued);
    repeat (30) @(posedge clk_i);
  endtask

  // finish any open frame and empty the ring
  task automatic flush_ring();
    settle();
    for (int unsigned i = 0; i < words_due; i++) enqueue(rnd_item(OP_SAMPLE));
    settle();
    queue_drains(ring_fill());
    settle();
  endtask

  // writes all three registers and the unused index, only while idle
  task automatic write_regs(input logic [7:0] v0, input logic [7:0] v1, input logic [7:0] v2);
    logic [7:0] vals [4];
    logic [1:0] idx;
    vals[0] = v0;
    vals[1] = v1;
    vals[2] = v2;
    vals[3] = $urandom;
    for (int i = 0; i < 4; i++) begin
      idx = i[1:0];
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        REG_SYNC_FIRST:  sync0_r = vals[i];
        REG_SYNC_SECOND: sync1_r = vals[i];
        REG_EVENT_TYPE:  type_r  = vals[i];
        default: ;  // REG_UNUSED, dropped by the block
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    frame_item_t it;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_regs(8'h55, 8'hAA, 8'h01);

    // directed: empty drain, stray sample, unused opcode
    enqueue(rnd_item(OP_DRAIN));
    enqueue(rnd_item(OP_SAMPLE));
    enqueue(rnd_item(OP_UNUSED));
    // zero-word frame closes right away, field extremes
    it = rnd_item(OP_HEADER);
    it.seq = '1; it.tms = '0; it.temp = 32'h8000_0000; it.fch = '1; it.cnt = 0; it.hg = 1'b0;
    enqueue(it);
    // one channel with high gain, opposite extremes
    it = rnd_item(OP_HEADER);
    it.seq = '0; it.tms = '1; it.temp = 32'h7FFF_FFFF; it.fch = '0; it.cnt = 1; it.hg = 1'b1;
    enqueue(it);
    // header while open is ignored
    it = rnd_item(OP_HEADER);
    it.cnt = '1; it.hg = 1'b1;
    enqueue(it);
    it = rnd_item(OP_SAMPLE);
    it.word = '0;
    enqueue(it);
    it.word = '1;
    enqueue(it);
    // high gain flag with no channels still closes at once
    it = rnd_item(OP_HEADER);
    it.cnt = 0; it.hg = 1'b1;
    enqueue(it);
    // drain in the middle of an open frame
    it = rnd_item(OP_HEADER);
    it.cnt = 2; it.hg = 1'b0;
    enqueue(it);
    enqueue(rnd_item(OP_SAMPLE));
    enqueue(rnd_item(OP_DRAIN));
    enqueue(rnd_item(OP_SAMPLE));
    queue_drains(8);
    flush_ring();

    // largest frame with interleaved drains, then mixed traffic
    write_regs($urandom, $urandom, $urandom);
    drain_pct = 40;
    queue_frame(255, 1'b1, 510);
    drain_pct = 15;
    queue_event_traffic(650);
    settle();

    // stretch with no gaps on either side
    write_regs(8'hFF, 8'hFF, 8'hFF);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    queue_event_traffic(650);
    settle();
    src_idle_pct  = 30;
    sink_idle_pct = 30;

    // fill the ring with zero-word frames until headers start to drop
    write_regs(8'h00, 8'h00, 8'h00);
    flush_ring();
    drain_pct = 0;
    for (int i = 0; i < 96; i++) begin
      it = rnd_item(OP_HEADER);
      it.cnt = 0;
      enqueue(it);
    end
    queue_frame(6, 1'b0, 6);    // two bytes short of room: dropped, samples ignored
    queue_frame(5, 1'b0, 5);    // fits exactly, leaves the ring full
    queue_frame(0, 1'b0, 0);
    enqueue(rnd_item(OP_DRAIN));
    queue_frame(0, 1'b1, 0);
    queue_drains(RING_SZ + 2);  // run the ring dry and past it
    settle();

    write_regs($urandom, $urandom, $urandom);
    drain_pct = 30;
    queue_frame(255, 1'b0, 255);
    drain_pct = 15;
    queue_event_traffic(600);
    settle();
    repeat (40) @(posedge clk_i);

    $display("run covered %0d items and %0d checked results", n_enqueued, n_checked);
    $display("%0d frames framed, %0d dropped, %0d bytes drained, ring peaked at %0d bytes",
             frames_built, drop_cnt, bytes_out, peak_fill);
    if (mismatches == 0 && result_due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
